/* sv/pab_pkg.sv */
// Shared types, constants and the arctangent table of the point angle and brightness block.
`timescale 1ns / 1ps
package pab_pkg;

  localparam int ANGLE_W      = 17;
  localparam int BRIGHT_W     = 8;
  localparam int MD_W         = 13;
  localparam int CORDIC_STEPS = 20;
  localparam int CORDIC_FRAC  = 16;
  localparam int Z_W          = 24;
  localparam int THETA_W      = 23;
  localparam int Q_W          = 16;
  localparam int NUM_W        = 21;
  localparam int DIV_STEPS    = 8;

  localparam logic [MD_W-1:0]     MD_RESET     = 13'd2264;
  localparam logic [Z_W-1:0]      QUARTER_TURN = 24'd5898240;
  localparam logic [Q_W-1:0]      Q_DOWN       = 16'd0;
  localparam logic [Q_W-1:0]      Q_UP         = 16'd46080;
  localparam logic [Q_W-1:0]      Q_FLAT       = 16'd23040;
  localparam logic [BRIGHT_W-1:0] BRIGHT_MAX   = 8'd255;

  typedef struct packed {
    logic dx_zero;
    logic dy_pos;
    logic dy_neg;
    logic same;
  } ang_flags_t;

  function automatic logic [Z_W-1:0] atan_tab(input int idx);
    logic [Z_W-1:0] v;
    unique case (idx)
      0:  v = 24'd2949120;
      1:  v = 24'd1740967;
      2:  v = 24'd919879;
      3:  v = 24'd466945;
      4:  v = 24'd234379;
      5:  v = 24'd117304;
      6:  v = 24'd58666;
      7:  v = 24'd29335;
      8:  v = 24'd14668;
      9:  v = 24'd7334;
      10: v = 24'd3667;
      11: v = 24'd1833;
      12: v = 24'd917;
      13: v = 24'd458;
      14: v = 24'd229;
      15: v = 24'd115;
      16: v = 24'd57;
      17: v = 24'd29;
      18: v = 24'd14;
      19: v = 24'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* sv/pab_if.sv */
// Valid/ready channel interfaces for input words, result words and configuration words.
`timescale 1ns / 1ps
interface pab_in_if #(parameter int COORD_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic [COORD_BITS-1:0] pointer_x;
  logic [COORD_BITS-1:0] pointer_y;
  logic                  last_point;
  modport source (output valid, point_x, point_y, pointer_x, pointer_y, last_point,
                  input ready);
  modport sink (input valid, point_x, point_y, pointer_x, pointer_y, last_point,
                output ready);
endinterface

interface pab_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pab_pkg::ANGLE_W-1:0]    angle;
  logic        [pab_pkg::BRIGHT_W-1:0]   brightness;
  logic                                  frame_end;
  modport source (output valid, angle, brightness, frame_end, input ready);
  modport sink (input valid, angle, brightness, frame_end, output ready);
endinterface

interface pab_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [pab_pkg::MD_W-1:0]    data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* sv/pab_delay.sv */
// Enabled register delay line for aligning the two pipeline paths.
`timescale 1ns / 1ps
module pab_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  generate
    if (DEPTH == 0) begin : g_none
      assign q = d;
    end else begin : g_line
      logic [W-1:0] tap_r [DEPTH];
      always_ff @(posedge clk) begin
        if (en) begin
          tap_r[0] <= d;
          for (int k = 1; k < DEPTH; k++) begin
            tap_r[k] <= tap_r[k-1];
          end
        end
      end
      assign q = tap_r[DEPTH-1];
    end
  endgenerate

endmodule

/* sv/pab_cordic.sv */
// Pipelined vectoring CORDIC that gives atan(b/a) in 1/65536 degree, one step per stage.
`timescale 1ns / 1ps
module pab_cordic #(
  parameter int COORD_BITS = 12
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [COORD_BITS-1:0]             a,
  input  logic [COORD_BITS-1:0]             b,
  input  pab_pkg::ang_flags_t               flags_in,
  output logic [pab_pkg::THETA_W-1:0]       theta,
  output pab_pkg::ang_flags_t               flags_out
);

  localparam int XW = COORD_BITS + pab_pkg::CORDIC_FRAC + 3;
  localparam int N  = pab_pkg::CORDIC_STEPS;

  logic signed [XW-1:0]          x_s [N+1];
  logic signed [XW-1:0]          y_s [N+1];
  logic signed [pab_pkg::Z_W-1:0] z_s [N+1];
  pab_pkg::ang_flags_t           f_s [N+1];

  assign x_s[0] = signed'({3'b000, a, {pab_pkg::CORDIC_FRAC{1'b0}}});
  assign y_s[0] = signed'({3'b000, b, {pab_pkg::CORDIC_FRAC{1'b0}}});
  assign z_s[0] = '0;
  assign f_s[0] = flags_in;

  generate
    for (genvar i = 0; i < N; i++) begin : g_step
      logic signed [XW-1:0]           x_r, y_r, x_nxt, y_nxt;
      logic signed [pab_pkg::Z_W-1:0] z_r, z_nxt;
      pab_pkg::ang_flags_t            f_r;

      always_comb begin
        logic signed [XW-1:0]           xsh;
        logic signed [XW-1:0]           ysh;
        logic signed [pab_pkg::Z_W-1:0] t;
        xsh = x_s[i] >>> i;
        ysh = y_s[i] >>> i;
        t   = signed'(pab_pkg::atan_tab(i));
        if (y_s[i] > 0) begin
          x_nxt = x_s[i] + ysh;
          y_nxt = y_s[i] - xsh;
          z_nxt = z_s[i] + t;
        end else if (y_s[i] < 0) begin
          x_nxt = x_s[i] - ysh;
          y_nxt = y_s[i] + xsh;
          z_nxt = z_s[i] - t;
        end else begin
          x_nxt = x_s[i];
          y_nxt = y_s[i];
          z_nxt = z_s[i];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          x_r <= x_nxt;
          y_r <= y_nxt;
          z_r <= z_nxt;
          f_r <= f_s[i];
        end
      end

      assign x_s[i+1] = x_r;
      assign y_s[i+1] = y_r;
      assign z_s[i+1] = z_r;
      assign f_s[i+1] = f_r;
    end
  endgenerate

  always_comb begin
    if (z_s[N] < 0) begin
      theta = '0;
    end else if (z_s[N] > signed'(pab_pkg::QUARTER_TURN)) begin
      theta = pab_pkg::QUARTER_TURN[pab_pkg::THETA_W-1:0];
    end else begin
      theta = z_s[N][pab_pkg::THETA_W-1:0];
    end
  end

  assign flags_out = f_s[N];

endmodule

/* sv/pab_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module pab_sqrt #(
  parameter int COORD_BITS = 12,
  parameter int SW         = 1
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [2*COORD_BITS:0]   n,
  input  logic [SW-1:0]           side_in,
  output logic [COORD_BITS:0]     root,
  output logic [SW-1:0]           side_out
);

  localparam int R   = COORD_BITS + 1;
  localparam int NPW = 2 * R;
  localparam int RW  = R + 3;

  logic [NPW-1:0] n_s    [R+1];
  logic [RW-1:0]  rem_s  [R+1];
  logic [R-1:0]   root_s [R+1];
  logic [SW-1:0]  side_s [R+1];

  assign n_s[0]    = {1'b0, n};
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign side_s[0] = side_in;

  generate
    for (genvar k = 0; k < R; k++) begin : g_step
      logic [NPW-1:0] n_r;
      logic [RW-1:0]  rem_r, rem_nxt;
      logic [R-1:0]   root_r, root_nxt;
      logic [SW-1:0]  side_r;

      always_comb begin
        logic [RW-1:0] rem_t;
        logic [RW-1:0] trial;
        rem_t = {rem_s[k][RW-3:0], n_s[k][NPW-1 -: 2]};
        trial = {1'b0, root_s[k], 2'b01};
        if (rem_t >= trial) begin
          rem_nxt  = rem_t - trial;
          root_nxt = {root_s[k][R-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_t;
          root_nxt = {root_s[k][R-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          n_r    <= n_s[k] << 2;
          rem_r  <= rem_nxt;
          root_r <= root_nxt;
          side_r <= side_s[k];
        end
      end

      assign n_s[k+1]    = n_r;
      assign rem_s[k+1]  = rem_r;
      assign root_s[k+1] = root_r;
      assign side_s[k+1] = side_r;
    end
  endgenerate

  assign root     = root_s[R];
  assign side_out = side_s[R];

endmodule

/* sv/pab_div.sv */
// Pipelined restoring divider for the 8-bit brightness quotient, one quotient bit per stage.
`timescale 1ns / 1ps
module pab_div #(
  parameter int SW = 1
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [pab_pkg::NUM_W-1:0]     num,
  input  logic [pab_pkg::MD_W-1:0]      den,
  input  logic [SW-1:0]                 side_in,
  output logic [pab_pkg::BRIGHT_W-1:0]  quo,
  output logic [SW-1:0]                 side_out
);

  localparam int N  = pab_pkg::DIV_STEPS;
  localparam int NW = pab_pkg::NUM_W;
  localparam int QW = pab_pkg::BRIGHT_W;

  logic [NW-1:0] rem_s  [N+1];
  logic [QW-1:0] quo_s  [N+1];
  logic [SW-1:0] side_s [N+1];

  assign rem_s[0]  = num;
  assign quo_s[0]  = '0;
  assign side_s[0] = side_in;

  generate
    for (genvar k = 0; k < N; k++) begin : g_step
      logic [NW-1:0] rem_r, rem_nxt;
      logic [QW-1:0] quo_r, quo_nxt;
      logic [SW-1:0] side_r;

      always_comb begin
        logic [NW-1:0] dsh;
        dsh = NW'(den) << (N - 1 - k);
        if (rem_s[k] >= dsh) begin
          rem_nxt = rem_s[k] - dsh;
          quo_nxt = {quo_s[k][QW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_s[k];
          quo_nxt = {quo_s[k][QW-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r  <= rem_nxt;
          quo_r  <= quo_nxt;
          side_r <= side_s[k];
        end
      end

      assign rem_s[k+1]  = rem_r;
      assign quo_s[k+1]  = quo_r;
      assign side_s[k+1] = side_r;
    end
  endgenerate

  assign quo      = quo_s[N];
  assign side_out = side_s[N];

endmodule

/* sv/point_angle_brightness_top.sv */
// Top level of the point angle and brightness pipeline.
// One word is accepted per cycle while the output register is free; otherwise all stages hold.
// The square root stages (COORD_BITS + 1), the divider stages and the 20 CORDIC stages set the depth.
// Reset clears all valid bits and loads max_distance with 2264.
`timescale 1ns / 1ps
module point_angle_brightness_top #(
  parameter int COORD_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  pab_in_if.sink               in_chan,
  pab_out_if.source            out_chan,
  pab_cfg_if.sink              cfg_chan
);

  localparam int L_ANG  = pab_pkg::CORDIC_STEPS + 1;
  localparam int L_DIST = COORD_BITS + 12;
  localparam int L_MAX  = (L_DIST > L_ANG) ? L_DIST : L_ANG;
  localparam int TOTAL  = L_MAX + 2;
  localparam int R      = COORD_BITS + 1;
  localparam int CMP_W  = (R > pab_pkg::MD_W) ? R : pab_pkg::MD_W;
  localparam int SQ_W   = 2 * COORD_BITS;

  logic                        en;
  logic [TOTAL-1:0]            vld_r;
  logic [pab_pkg::MD_W-1:0]    md_r;

  assign en          = !vld_r[TOTAL-1] || out_chan.ready;
  assign in_chan.ready  = en;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      md_r  <= pab_pkg::MD_RESET;
    end else begin
      if (en) begin
        vld_r <= {vld_r[TOTAL-2:0], in_chan.valid};
      end
      if (cfg_chan.valid) begin
        md_r <= cfg_chan.data;
      end
    end
  end

  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS-1:0]      adx_nxt, ady_nxt, adx_r, ady_r;
  pab_pkg::ang_flags_t        flags_nxt, flags_a_r;
  logic                       last_a_r;
  logic                       dx_pos, dy_pos;

  always_comb begin
    dx      = signed'({1'b0, in_chan.pointer_x}) - signed'({1'b0, in_chan.point_x});
    dy      = signed'({1'b0, in_chan.pointer_y}) - signed'({1'b0, in_chan.point_y});
    adx_nxt = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    ady_nxt = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
    dx_pos  = !dx[COORD_BITS] && (dx != 0);
    dy_pos  = !dy[COORD_BITS] && (dy != 0);
    flags_nxt.dx_zero = (dx == 0);
    flags_nxt.dy_pos  = dy_pos;
    flags_nxt.dy_neg  = dy[COORD_BITS];
    flags_nxt.same    = (dx_pos == dy_pos) || (dy == 0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adx_r     <= adx_nxt;
      ady_r     <= ady_nxt;
      flags_a_r <= flags_nxt;
      last_a_r  <= in_chan.last_point;
    end
  end

  // Angle path.
  logic [pab_pkg::THETA_W-1:0] theta;
  pab_pkg::ang_flags_t         flags_c;
  logic [pab_pkg::ANGLE_W-1:0] ang_nxt, ang_r, ang_d;

  pab_cordic #(.COORD_BITS(COORD_BITS)) u_cordic (
    .clk       (clk),
    .en        (en),
    .a         (adx_r),
    .b         (ady_r),
    .flags_in  (flags_a_r),
    .theta     (theta),
    .flags_out (flags_c)
  );

  always_comb begin
    logic [pab_pkg::Z_W-1:0] qsum;
    logic [pab_pkg::Q_W-1:0] q;
    qsum = flags_c.same ? (pab_pkg::QUARTER_TURN - pab_pkg::Z_W'(theta))
                        : (pab_pkg::QUARTER_TURN + pab_pkg::Z_W'(theta));
    if (flags_c.dx_zero) begin
      if (flags_c.dy_pos) begin
        q = pab_pkg::Q_DOWN;
      end else if (flags_c.dy_neg) begin
        q = pab_pkg::Q_UP;
      end else begin
        q = pab_pkg::Q_FLAT;
      end
    end else begin
      q = qsum[pab_pkg::Z_W-1 -: pab_pkg::Q_W];
    end
    ang_nxt = pab_pkg::ANGLE_W'(0) - {1'b0, q};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r <= ang_nxt;
    end
  end

  pab_delay #(.W(pab_pkg::ANGLE_W), .DEPTH(L_MAX - L_ANG)) u_ang_dly (
    .clk (clk),
    .en  (en),
    .d   (ang_r),
    .q   (ang_d)
  );

  // Distance path.
  logic [SQ_W-1:0]   sqx_r, sqy_r;
  logic              last_b1_r, last_b2_r;
  logic [SQ_W:0]     sum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r     <= adx_r * adx_r;
      sqy_r     <= ady_r * ady_r;
      last_b1_r <= last_a_r;
      sum_r     <= {1'b0, sqx_r} + {1'b0, sqy_r};
      last_b2_r <= last_b1_r;
    end
  end

  logic [R-1:0] root;
  logic         last_s;

  pab_sqrt #(.COORD_BITS(COORD_BITS), .SW(1)) u_sqrt (
    .clk      (clk),
    .en       (en),
    .n        (sum_r),
    .side_in  (last_b2_r),
    .root     (root),
    .side_out (last_s)
  );

  logic [pab_pkg::NUM_W-1:0] num_nxt, num_r;
  logic                      last_c_r;

  always_comb begin
    logic [CMP_W-1:0]        root_e;
    logic [CMP_W-1:0]        md_e;
    logic [CMP_W-1:0]        dmin;
    logic [pab_pkg::MD_W-1:0] dc;
    root_e  = CMP_W'(root);
    md_e    = CMP_W'(md_r);
    dmin    = (root_e < md_e) ? root_e : md_e;
    dc      = dmin[pab_pkg::MD_W-1:0];
    num_nxt = pab_pkg::NUM_W'(pab_pkg::BRIGHT_MAX) * pab_pkg::NUM_W'(md_r - dc);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r    <= num_nxt;
      last_c_r <= last_s;
    end
  end

  logic [pab_pkg::BRIGHT_W-1:0] quo, quo_d;
  logic                         last_q, last_d;

  pab_div #(.SW(1)) u_div (
    .clk      (clk),
    .en       (en),
    .num      (num_r),
    .den      (md_r),
    .side_in  (last_c_r),
    .quo      (quo),
    .side_out (last_q)
  );

  pab_delay #(.W(pab_pkg::BRIGHT_W + 1), .DEPTH(L_MAX - L_DIST)) u_dist_dly (
    .clk (clk),
    .en  (en),
    .d   ({quo, last_q}),
    .q   ({quo_d, last_d})
  );

  // Output register.
  logic [pab_pkg::ANGLE_W-1:0]  out_angle_r;
  logic [pab_pkg::BRIGHT_W-1:0] out_bright_r;
  logic                         out_fe_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_angle_r  <= ang_d;
      out_bright_r <= (md_r == '0) ? '0 : quo_d;
      out_fe_r     <= last_d;
    end
  end

  assign out_chan.valid      = vld_r[TOTAL-1];
  assign out_chan.angle      = signed'(out_angle_r);
  assign out_chan.brightness = out_bright_r;
  assign out_chan.frame_end  = out_fe_r;

endmodule

/* sv/pab_checker.sv */
// Port-level checker for the point angle and brightness block, bound to the top level.
`timescale 1ns / 1ps
module pab_port_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [pab_pkg::ANGLE_W-1:0] angle,
  input logic [pab_pkg::BRIGHT_W-1:0]      brightness
);

  a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow the output register state");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(angle) && $stable(brightness))
    else $error("stalled result word changed");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (angle <= 0) && (angle >= -46080))
    else $error("angle out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  a_handshake_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_valid, in_ready, out_valid}))
    else $error("handshake signal is unknown");

endmodule

bind point_angle_brightness_top pab_port_checker u_pab_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .angle      (out_chan.angle),
  .brightness (out_chan.brightness)
);

/* bench/pab_checker.sv */
// Checker that predicts the angle, brightness and frame end of each input word and compares results.
`timescale 1ns / 1ps
module pab_checker (
  input  logic clk,
  input  logic rst_n,
  pab_in_if    in_mon,
  pab_out_if   out_mon,
  pab_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic signed [pab_pkg::ANGLE_W-1:0] angle;
    logic [pab_pkg::BRIGHT_W-1:0]       brightness;
    logic                               frame_end;
  } pab_result_t;

  localparam longint QTURN = 64'sd5898240;
  localparam longint ATAN_DEG [20] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

  logic [pab_pkg::MD_W-1:0] cur_max_dist;
  pab_result_t              expected_results[$];

  function automatic longint cordic_theta(longint a, longint b);
    longint x, y, z, xs, ys;
    x = a <<< 16;
    y = b <<< 16;
    z = 0;
    for (int i = 0; i < 20; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_DEG[i];
      end else if (y < 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_DEG[i];
      end
    end
    if (z < 0) z = 0;
    if (z > QTURN) z = QTURN;
    return z;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic pab_result_t predict_point(longint px, longint py, longint mx,
                                                longint my, logic lp,
                                                logic [pab_pkg::MD_W-1:0] md);
    pab_result_t r;
    longint dx, dy, adx, ady, q, theta, v;
    longint unsigned d, mdl, br;
    bit same;
    dx = mx - px;
    dy = my - py;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    if (dx == 0) begin
      if (dy > 0) q = 0;
      else if (dy < 0) q = 180 * 256;
      else q = 90 * 256;
    end else begin
      theta = cordic_theta(adx, ady);
      same = ((dx > 0) == (dy > 0)) || (dy == 0);
      v = same ? theta - QTURN : -theta - QTURN;
      q = (-v) >>> 8;
    end
    mdl = 64'(md);
    d = root_floor(64'(adx * adx + ady * ady));
    if (d > mdl) d = mdl;
    br = (mdl != 0) ? (255 * (mdl - d)) / mdl : 0;
    r.angle = pab_pkg::ANGLE_W'(-q);
    r.brightness = br[7:0];
    r.frame_end = lp;
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    pab_result_t want;
    if (!rst_n) begin
      cur_max_dist <= pab_pkg::MD_RESET;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with no expectation waiting");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_mon.angle !== want.angle || out_mon.brightness !== want.brightness ||
              out_mon.frame_end !== want.frame_end) begin
            fail_count <= fail_count + 1;
            if (out_mon.angle !== want.angle)
              $error("angle expected %0d actual %0d", want.angle, out_mon.angle);
            if (out_mon.brightness !== want.brightness)
              $error("brightness expected %0d actual %0d", want.brightness,
                     out_mon.brightness);
            if (out_mon.frame_end !== want.frame_end)
              $error("frame_end expected %0d actual %0d", want.frame_end,
                     out_mon.frame_end);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(predict_point(longint'(in_mon.point_x),
                                                 longint'(in_mon.point_y),
                                                 longint'(in_mon.pointer_x),
                                                 longint'(in_mon.pointer_y),
                                                 in_mon.last_point, cur_max_dist));
      if (cfg_mon.valid && cfg_mon.ready)
        cur_max_dist <= cfg_mon.data;
    end
  end
endmodule

/* bench/tb_point_angle_brightness_top.sv */
// Testbench top that drives grid points and distance settings into the block and gives the verdict.
`timescale 1ns / 1ps
module tb_point_angle_brightness_top;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   idle_on = 1'b1;
  int   fail_count, pending, quiet_cycles;

  pab_in_if #(.COORD_BITS(12)) in_ch();
  pab_out_if out_ch();
  pab_cfg_if cfg_ch();

  point_angle_brightness_top #(.COORD_BITS(12)) dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_ch), .out_chan(out_ch), .cfg_chan(cfg_ch));

  pab_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .fail_count(fail_count), .pending(pending));

  always #2 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.pointer_x = '0;
    in_ch.pointer_y = '0;
    in_ch.last_point = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 3000) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20) - 1) @(negedge clk);
      end
    end
  end

  task automatic send_point(int px, int py, int mx, int my, bit lp);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.point_x <= px[11:0];
    in_ch.point_y <= py[11:0];
    in_ch.pointer_x <= mx[11:0];
    in_ch.pointer_y <= my[11:0];
    in_ch.last_point <= lp;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_max_dist(logic [pab_pkg::MD_W-1:0] md);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= md;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_point();
    int mx, my, ox, oy;
    mx = $urandom_range(0, 4095);
    my = $urandom_range(0, 4095);
    case ($urandom_range(0, 9))
      0, 1, 2: begin ox = $urandom_range(0, 4095) - mx; oy = $urandom_range(0, 4095) - my; end
      3, 4: begin ox = $urandom_range(0, 128) - 64; oy = $urandom_range(0, 128) - 64; end
      5: begin ox = 0; oy = $urandom_range(0, 4095) - my; end
      6: begin ox = $urandom_range(0, 4095) - mx; oy = 0; end
      7: begin ox = 0; oy = 0; end
      8: begin
        mx = $urandom_range(0, 1) * 4095; my = $urandom_range(0, 1) * 4095;
        ox = $urandom_range(0, 1) * 4095 - mx; oy = $urandom_range(0, 1) * 4095 - my;
      end
      default: begin ox = $urandom_range(0, 2000) - 1000; oy = ox + $urandom_range(0, 4) - 2; end
    endcase
    send_point((mx + ox) & 4095, (my + oy) & 4095, mx, my, $urandom_range(0, 1));
  endtask

  initial begin
    logic [pab_pkg::MD_W-1:0] settings [8];
    settings = '{13'd8191, 13'd1, 13'd0, 13'd100, 13'd5000, 13'd2264, 13'd37, 13'd8191};
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_point(0, 0, 0, 0, 1'b0);
    send_point(0, 0, 4095, 4095, 1'b1);
    send_point(4095, 4095, 0, 0, 1'b0);
    send_point(0, 4095, 4095, 0, 1'b1);
    send_point(4095, 0, 0, 4095, 1'b0);
    send_point(100, 100, 100, 4000, 1'b0);
    send_point(100, 4000, 100, 100, 1'b1);
    send_point(2000, 2000, 2000, 2000, 1'b0);
    send_point(0, 500, 4095, 500, 1'b0);
    send_point(4095, 500, 0, 500, 1'b1);
    send_point(10, 10, 11, 10, 1'b0);
    send_point(10, 10, 10, 11, 1'b0);
    send_point(10, 10, 10, 9, 1'b0);
    send_point(10, 10, 11, 11, 1'b1);
    send_point(10, 10, 9, 11, 1'b0);
    send_point(1000, 1000, 2600, 2600, 1'b0);
    send_point(2730, 1365, 1365, 2730, 1'b1);
    send_point(4095, 4095, 4095, 4095, 1'b1);
    for (int k = 0; k < 120; k++) random_point();
    foreach (settings[s]) begin
      write_max_dist(settings[s]);
      if (s == 7) idle_on = 1'b0;
      for (int k = 0; k < 135; k++) random_point();
    end
    write_max_dist(pab_pkg::MD_W'($urandom_range(1, 8191)));
    for (int k = 0; k < 60; k++) random_point();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
